[rtl/core/bzbb_pkg.sv]
`timescale 1ns / 1ps
// shared constants of the bezier bounding box core
// no dependencies; imported by the top level and the curve evaluator

package bzbb_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int T_FRAC_BITS_DEF = 16;
	// fraction bits of the points inside the de casteljau evaluation
	localparam int PT_FRAC = 8;
	// root lanes: two per axis
	localparam int NUM_LANES = 4;

endpackage

[rtl/core/bzbb_isqrt.sv]
`timescale 1ns / 1ps
// pipelined integer square root, one root bit per stage, floor result
// no dependencies

module bzbb_isqrt #(
	parameter int OUT_W = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [2*OUT_W-1:0]   rad,
	output logic [OUT_W-1:0]     root
);

	logic [OUT_W:0]       rem_q  [1:OUT_W];
	logic [OUT_W-1:0]     root_q [1:OUT_W];
	logic [2*OUT_W-1:0]   rad_q  [1:OUT_W];

	for (genvar k = 0; k < OUT_W; k++) begin : g_stage
		logic [OUT_W:0]     rem_i;
		logic [OUT_W-1:0]   root_i;
		logic [2*OUT_W-1:0] rad_i;
		logic [OUT_W+2:0]   cur;
		logic [OUT_W+2:0]   trial;
		logic [OUT_W+2:0]   diff;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad;
		end else begin : g_next
			assign rem_i  = rem_q[k];
			assign root_i = root_q[k];
			assign rad_i  = rad_q[k];
		end

		assign cur   = {rem_i, rad_i[2*OUT_W-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign diff  = cur - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					rem_q[k+1]  <= diff[OUT_W:0];
					root_q[k+1] <= {root_i[OUT_W-2:0], 1'b1};
				end else begin
					rem_q[k+1]  <= cur[OUT_W:0];
					root_q[k+1] <= {root_i[OUT_W-2:0], 1'b0};
				end
				rad_q[k+1] <= rad_i << 2;
			end
		end
	end

	assign root = root_q[OUT_W];

endmodule

[rtl/core/bzbb_div.sv]
`timescale 1ns / 1ps
// root lane divider: t = round(num/den) in q1.TF when 0 <= num/den <= 1
// restoring division, one quotient bit per stage; no dependencies

module bzbb_div #(
	parameter int NW = 35,
	parameter int TF = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic                 ena,
	input  logic signed [NW-1:0] num,
	input  logic signed [NW-1:0] den,
	output logic [TF:0]          t,
	output logic                 ok
);

	localparam int UW = NW - 1;

	logic signed [NW-1:0] nn;
	logic signed [NW-1:0] dd;
	logic                 good;

	logic [UW:0]   r_q  [TF+2];
	logic [UW-1:0] d_q  [TF+2];
	logic [TF:0]   q_q  [TF+2];
	logic          ok_q [TF+2];

	logic [TF:0]   t_q;
	logic          okf_q;
	logic          inc;

	always_comb begin
		nn   = den[NW-1] ? -num : num;
		dd   = den[NW-1] ? -den : den;
		good = ena && (dd != '0) && !nn[NW-1] && (nn <= dd);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q[0]  <= {1'b0, nn[UW-1:0]};
			d_q[0]  <= dd[UW-1:0];
			q_q[0]  <= '0;
			ok_q[0] <= good;
		end
	end

	for (genvar j = 0; j <= TF; j++) begin : g_step
		logic        ge;
		logic [UW:0] rn;

		assign ge = r_q[j] >= {1'b0, d_q[j]};
		assign rn = ge ? (r_q[j] - {1'b0, d_q[j]}) : r_q[j];

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[j+1]  <= {rn[UW-1:0], 1'b0};
				d_q[j+1]  <= d_q[j];
				q_q[j+1]  <= {q_q[j][TF-1:0], ge};
				ok_q[j+1] <= ok_q[j];
			end
		end
	end

	assign inc = r_q[TF+1] >= {1'b0, d_q[TF+1]};

	always_ff @(posedge clk) begin
		if (en) begin
			t_q   <= q_q[TF+1] + (TF+1)'(inc);
			okf_q <= ok_q[TF+1];
		end
	end

	assign t  = t_q;
	assign ok = okf_q;

endmodule

[rtl/core/bzbb_eval.sv]
`timescale 1ns / 1ps
// pipelined de casteljau evaluation of one axis at parameter t
// depends on bzbb_pkg for the point fraction width

module bzbb_eval #(
	parameter int CW = 16,
	parameter int TF = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic                 cubic,
	input  logic [3:0][CW-1:0]   p,
	input  logic [TF:0]          t,
	output logic signed [CW-1:0] coord
);

	import bzbb_pkg::*;

	localparam int WW = CW + PT_FRAC;
	localparam int DW = WW + 1;
	localparam int PW = DW + TF + 2;

	logic signed [WW-1:0] wa_q [3][4];
	logic signed [PW-1:0] pr_q [3][3];
	logic [TF:0]          ta_q [3];
	logic                 ca_q [3];
	logic signed [WW-1:0] wb_q [3][4];
	logic [TF:0]          tb_q [3];
	logic                 cb_q [3];

	logic signed [WW-1:0] cs;
	logic signed [CW-1:0] coord_q;

	for (genvar l = 0; l < 3; l++) begin : g_lvl
		logic signed [WW-1:0] w_i [4];
		logic [TF:0]          t_i;
		logic                 c_i;
		logic signed [TF+1:0] ts;
		logic signed [DW-1:0] df [3];
		logic signed [PW-1:0] rs [3];

		if (l == 0) begin : g_first
			for (genvar k = 0; k < 4; k++) begin : g_pt
				assign w_i[k] = $signed({p[k], {PT_FRAC{1'b0}}});
			end
			assign t_i = t;
			assign c_i = cubic;
		end else begin : g_next
			for (genvar k = 0; k < 4; k++) begin : g_pt
				assign w_i[k] = wb_q[l-1][k];
			end
			assign t_i = tb_q[l-1];
			assign c_i = cb_q[l-1];
		end

		assign ts = $signed({1'b0, t_i});

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				df[k] = DW'(w_i[k+1]) - DW'(w_i[k]);
				rs[k] = (pr_q[l][k] + (PW'(1) <<< (TF - 1))) >>> TF;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 4; k++) wa_q[l][k] <= w_i[k];
				for (int k = 0; k < 3; k++) pr_q[l][k] <= PW'(df[k]) * PW'(ts);
				ta_q[l] <= t_i;
				ca_q[l] <= c_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					// a quadratic curve is done after two levels
					if (k == 0 && l == 2 && !ca_q[l]) wb_q[l][k] <= wa_q[l][k];
					else wb_q[l][k] <= wa_q[l][k] + rs[k][WW-1:0];
				end
				wb_q[l][3] <= wa_q[l][3];
				tb_q[l] <= ta_q[l];
				cb_q[l] <= ca_q[l];
			end
		end
	end

	assign cs = wb_q[2][0] + (WW'(1) <<< (PT_FRAC - 1));

	always_ff @(posedge clk) begin
		if (en) coord_q <= cs[WW-1:PT_FRAC];
	end

	assign coord = coord_q;

endmodule

[rtl/core/bzbb_delay.sv]
`timescale 1ns / 1ps
// stallable delay line that keeps side data aligned with the pipelined units
// no dependencies

module bzbb_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] sr_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) sr_q[i] <= sr_q[i-1];
		end
	end

	assign dout = sr_q[DEPTH-1];

endmodule

[rtl/core/bezier_bounding_box.sv]
`timescale 1ns / 1ps
// bezier_bounding_box: tight bounding box of a quadratic or cubic bezier curve
// depends on bzbb_pkg, bzbb_isqrt, bzbb_div, bzbb_eval, bzbb_delay
//
// channel   dir  signals                   contents
// s_axis    in   tvalid tready tdata tuser  one curve: control points, degree
// m_axis    out  tvalid tready tdata        one box: min and max corners
//
// one item per clock sustained while the output is taken; the latency is set by
// the square root pipeline (one bit per stage) and the root dividers (one
// quotient bit per stage)
// arst_n clears the valid pipeline only; the pipeline stalls only when the output
// register is full and not taken and the stage before it holds an item

module bezier_bounding_box #(
	parameter int COORD_WIDTH = bzbb_pkg::COORD_WIDTH_DEF,
	parameter int T_FRAC_BITS = bzbb_pkg::T_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
	input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// mode
	input  logic [0:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// min_x, min_y, max_x, max_y
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

	import bzbb_pkg::*;

	localparam int CW     = COORD_WIDTH;
	localparam int TF     = T_FRAC_BITS;
	localparam int SQ     = ((61 - 2*CW) > 0) ? ((61 - 2*CW) / 2) : 0;
	localparam int SQW    = CW + 2 + SQ;
	localparam int SQIN_W = 2 * SQW;
	localparam int PRW    = 2*CW + 4;
	localparam int DSW    = 2*CW + 5;
	localparam int NW     = SQW + 3;
	localparam int LAT    = SQW + TF + 16;
	localparam int OUT_DW = ((4*CW+7)/8)*8;

	typedef struct packed {
		logic                      mode;
		logic [1:0]                neg;
		logic [1:0][CW+2:0]        a;
		logic [1:0][CW+1:0]        h;
		logic [1:0][CW:0]          c;
		logic [1:0][3:0][CW-1:0]   p;
		logic [1:0][CW-1:0]        lo;
		logic [1:0][CW-1:0]        hi;
	} ctx_t;

	typedef struct packed {
		logic [NUM_LANES-1:0]      ok;
		logic [1:0][CW-1:0]        lo;
		logic [1:0][CW-1:0]        hi;
	} box_t;

	logic             out_take;
	logic             en;
	logic [LAT-1:0]   vld_q;
	logic             out_vld_q;

	logic                    mode_s1;
	logic [1:0][3:0][CW-1:0] p_s1;

	logic signed [CW+2:0] e_p [2][4];
	logic signed [CW+2:0] c_w [2];
	logic signed [CW+2:0] h_w [2];
	logic signed [CW+2:0] d12 [2];
	logic signed [CW+2:0] a_w [2];
	logic signed [CW+2:0] end_w [2];
	ctx_t                 ctx_n;
	ctx_t                 ctx_s2;
	ctx_t                 ctx_s3;
	ctx_t                 ctx_m;
	ctx_t                 ctx_s4;
	ctx_t                 ctx_d;
	ctx_t                 ctx_s5;
	ctx_t                 ctx_v;

	logic signed [PRW-1:0] hh_s3 [2];
	logic signed [PRW-1:0] ac_s3 [2];
	logic signed [DSW-1:0] disc_w [2];
	logic signed [DSW-1:0] disc_s4 [2];
	logic [SQIN_W-1:0]     sq_in [2];
	logic [SQW-1:0]        sq_r [2];

	logic signed [NW-1:0] h_e [2];
	logic signed [NW-1:0] c_e [2];
	logic signed [NW-1:0] a_e [2];
	logic signed [NW-1:0] hs [2];
	logic signed [NW-1:0] sv [2];
	logic signed [NW-1:0] n_n [NUM_LANES];
	logic signed [NW-1:0] d_n [NUM_LANES];
	logic                 ena_n [NUM_LANES];
	logic signed [NW-1:0] n_s5 [NUM_LANES];
	logic signed [NW-1:0] d_s5 [NUM_LANES];
	logic                 ena_s5 [NUM_LANES];

	logic [TF:0]          t_v [NUM_LANES];
	logic [NUM_LANES-1:0] ok_v;
	box_t                 box_n;
	box_t                 box_e;
	logic signed [CW-1:0] ev [NUM_LANES][2];

	logic signed [CW-1:0] mn [2];
	logic signed [CW-1:0] mx [2];
	logic [CW-1:0]        lo_s6 [2];
	logic [CW-1:0]        hi_s6 [2];
	logic [CW-1:0]        lo_q [2];
	logic [CW-1:0]        hi_q [2];

	// flow control
	assign out_take      = !out_vld_q || m_axis_tready;
	assign en            = out_take || !vld_q[LAT-1];
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (en) vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
			if (out_take) out_vld_q <= vld_q[LAT-1];
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= s_axis_tuser[0];
			for (int k = 0; k < 4; k++) begin
				p_s1[0][k] <= s_axis_tdata[(2*k)*CW +: CW];
				p_s1[1][k] <= s_axis_tdata[(2*k+1)*CW +: CW];
			end
		end
	end

	// derivative coefficients and end point box
	always_comb begin
		ctx_n      = '0;
		ctx_n.mode = mode_s1;
		ctx_n.p    = p_s1;
		for (int ax = 0; ax < 2; ax++) begin
			for (int k = 0; k < 4; k++) e_p[ax][k] = (CW+3)'($signed(p_s1[ax][k]));
			c_w[ax]   = e_p[ax][1] - e_p[ax][0];
			h_w[ax]   = e_p[ax][0] - (e_p[ax][1] <<< 1) + e_p[ax][2];
			d12[ax]   = e_p[ax][1] - e_p[ax][2];
			a_w[ax]   = e_p[ax][3] - e_p[ax][0] + (d12[ax] <<< 1) + d12[ax];
			end_w[ax] = mode_s1 ? e_p[ax][3] : e_p[ax][2];
			ctx_n.c[ax] = c_w[ax][CW:0];
			ctx_n.h[ax] = h_w[ax][CW+1:0];
			ctx_n.a[ax] = a_w[ax][CW+2:0];
			if (e_p[ax][0] < end_w[ax]) begin
				ctx_n.lo[ax] = p_s1[ax][0];
				ctx_n.hi[ax] = end_w[ax][CW-1:0];
			end else begin
				ctx_n.lo[ax] = end_w[ax][CW-1:0];
				ctx_n.hi[ax] = p_s1[ax][0];
			end
		end
	end

	always_comb begin
		for (int ax = 0; ax < 2; ax++) disc_w[ax] = DSW'(hh_s3[ax]) - DSW'(ac_s3[ax]);
		ctx_m     = ctx_s3;
		ctx_m.neg = {disc_w[1][DSW-1], disc_w[0][DSW-1]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= ctx_n;
			ctx_s3 <= ctx_s2;
			for (int ax = 0; ax < 2; ax++) begin
				hh_s3[ax] <= PRW'($signed(ctx_s2.h[ax])) * PRW'($signed(ctx_s2.h[ax]));
				ac_s3[ax] <= PRW'($signed(ctx_s2.a[ax])) * PRW'($signed(ctx_s2.c[ax]));
				disc_s4[ax] <= disc_w[ax];
			end
			ctx_s4 <= ctx_m;
		end
	end

	for (genvar ax = 0; ax < 2; ax++) begin : g_sqrt
		assign sq_in[ax] = SQIN_W'(disc_s4[ax][PRW-1:0]) << (2*SQ);

		bzbb_isqrt #(
			.OUT_W(SQW)
		) u_isqrt (
			.clk (clk),
			.en  (en),
			.rad (sq_in[ax]),
			.root(sq_r[ax])
		);
	end

	bzbb_delay #(
		.WIDTH($bits(ctx_t)),
		.DEPTH(SQW)
	) u_dly_sqrt (
		.clk (clk),
		.en  (en),
		.din (ctx_s4),
		.dout(ctx_d)
	);

	// root candidates n/d per lane: plus and minus root of each axis, or one linear root when quadratic or a is zero
	always_comb begin
		for (int ax = 0; ax < 2; ax++) begin
			h_e[ax] = NW'($signed(ctx_d.h[ax]));
			c_e[ax] = NW'($signed(ctx_d.c[ax]));
			a_e[ax] = NW'($signed(ctx_d.a[ax]));
			hs[ax]  = h_e[ax] <<< SQ;
			sv[ax]  = $signed({{(NW-SQW){1'b0}}, sq_r[ax]});
			n_n[2*ax]     = -c_e[ax];
			n_n[2*ax+1]   = -c_e[ax];
			d_n[2*ax]     = h_e[ax];
			d_n[2*ax+1]   = h_e[ax];
			ena_n[2*ax]   = 1'b1;
			ena_n[2*ax+1] = 1'b0;
			if (ctx_d.mode) begin
				if (ctx_d.a[ax] == '0) begin
					d_n[2*ax] = h_e[ax] <<< 1;
				end else begin
					n_n[2*ax]     = sv[ax] - hs[ax];
					n_n[2*ax+1]   = -hs[ax] - sv[ax];
					d_n[2*ax]     = a_e[ax] <<< SQ;
					d_n[2*ax+1]   = a_e[ax] <<< SQ;
					ena_n[2*ax]   = !ctx_d.neg[ax];
					ena_n[2*ax+1] = !ctx_d.neg[ax];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5 <= ctx_d;
			for (int l = 0; l < NUM_LANES; l++) begin
				n_s5[l]   <= n_n[l];
				d_s5[l]   <= d_n[l];
				ena_s5[l] <= ena_n[l];
			end
		end
	end

	bzbb_delay #(
		.WIDTH($bits(ctx_t)),
		.DEPTH(TF + 3)
	) u_dly_div (
		.clk (clk),
		.en  (en),
		.din (ctx_s5),
		.dout(ctx_v)
	);

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		bzbb_div #(
			.NW(NW),
			.TF(TF)
		) u_div (
			.clk (clk),
			.en  (en),
			.ena (ena_s5[l]),
			.num (n_s5[l]),
			.den (d_s5[l]),
			.t   (t_v[l]),
			.ok  (ok_v[l])
		);

		for (genvar ax = 0; ax < 2; ax++) begin : g_axis
			bzbb_eval #(
				.CW(CW),
				.TF(TF)
			) u_eval (
				.clk  (clk),
				.en   (en),
				.cubic(ctx_v.mode),
				.p    (ctx_v.p[ax]),
				.t    (t_v[l]),
				.coord(ev[l][ax])
			);
		end
	end

	assign box_n.ok = ok_v;
	assign box_n.lo = ctx_v.lo;
	assign box_n.hi = ctx_v.hi;

	bzbb_delay #(
		.WIDTH($bits(box_t)),
		.DEPTH(7)
	) u_dly_eval (
		.clk (clk),
		.en  (en),
		.din (box_n),
		.dout(box_e)
	);

	// merge lane points into the end point box
	always_comb begin
		for (int ax = 0; ax < 2; ax++) begin
			mn[ax] = $signed(box_e.lo[ax]);
			mx[ax] = $signed(box_e.hi[ax]);
			for (int l = 0; l < NUM_LANES; l++) begin
				if (box_e.ok[l]) begin
					if (ev[l][ax] < mn[ax]) mn[ax] = ev[l][ax];
					if (ev[l][ax] > mx[ax]) mx[ax] = ev[l][ax];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ax = 0; ax < 2; ax++) begin
				lo_s6[ax] <= mn[ax];
				hi_s6[ax] <= mx[ax];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			lo_q <= lo_s6;
			hi_q <= hi_s6;
		end
	end

	assign m_axis_tdata = OUT_DW'({hi_q[1], hi_q[0], lo_q[1], lo_q[0]});

endmodule
